@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros used by the checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ design/gmdfs_pkg.sv @@
// ----------------------------------------------------------------------------
// gmdfs_pkg
// shared types and constants of the grid maze path search block
// ----------------------------------------------------------------------------
package gmdfs_pkg;

    localparam int CFG_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int ROW_IDX_W = 3;
    localparam int WALL_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int COORD_W   = 3;
    localparam int DIR_W     = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_COL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_ROW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GOAL_COL  = 2'd3;

    localparam logic [CFG_W-1:0] START_ROW_RESET = 3'd0;
    localparam logic [CFG_W-1:0] START_COL_RESET = 3'd1;
    localparam logic [CFG_W-1:0] GOAL_ROW_RESET  = 3'd7;
    localparam logic [CFG_W-1:0] GOAL_COL_RESET  = 3'd7;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_STEP          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_PATH       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_START_BLOCKED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_GOAL_BLOCKED  = 2'd3;

    // neighbor order: column+1, row+1, column-1, row-1
    localparam logic [DIR_W-1:0] DIR_EAST  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_SOUTH = 3'd1;
    localparam logic [DIR_W-1:0] DIR_WEST  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_NORTH = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

    typedef enum logic [1:0] {
        SRC_CODE,
        SRC_START,
        SRC_STACK,
        SRC_TOP
    } res_src_t;

    typedef struct packed {
        logic                load_row;
        logic                init_search;
        logic                advance;
        logic                flood_init;
        logic                flood_step;
        logic                push;
        logic                push_cand;
        logic                pop;
        logic                load_top;
        logic                emit_clear;
        logic                emit_rd;
        logic                emit_adv;
        logic                res_load;
        logic                res_last;
        res_src_t            res_src;
        logic [STATUS_W-1:0] res_code;
    } ctrl_cmd_t;

    typedef struct packed {
        logic start_wall;
        logic goal_wall;
        logic start_is_goal;
        logic start_in_grid;
        logic dir_end;
        logic level_one;
        logic level_full;
        logic budget_zero;
        logic nbr_is_goal;
        logic nbr_free;
        logic flood_goal;
        logic flood_stuck;
        logic emit_next_top;
    } dp_status_t;

endpackage

@@ design/gmdfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// gmdfs_ctrl
// sequencer for row loading, the backtracking search, the reachability
// flood and the result stream
// ----------------------------------------------------------------------------
module gmdfs_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   last_row,
    input  gmdfs_pkg::dp_status_t  stat,
    output gmdfs_pkg::ctrl_cmd_t   cmd,
    output logic                   busy
);
    import gmdfs_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_CHECK    = 8'b0000_0010,
        S_STEP     = 8'b0000_0100,
        S_FLOOD    = 8'b0000_1000,
        S_LOAD     = 8'b0001_0000,
        S_EMIT_RD  = 8'b0010_0000,
        S_EMIT_OUT = 8'b0100_0000,
        S_EMIT_TOP = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_row = 1'b1;
                    if (last_row)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                state_next = S_IDLE;
                if (stat.start_wall)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_last = 1'b1;
                    cmd.res_src  = SRC_CODE;
                    cmd.res_code = ST_START_BLOCKED;
                end
                else if (stat.goal_wall)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_last = 1'b1;
                    cmd.res_src  = SRC_CODE;
                    cmd.res_code = ST_GOAL_BLOCKED;
                end
                else if (stat.start_is_goal)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_last = 1'b1;
                    cmd.res_src  = SRC_START;
                    cmd.res_code = ST_STEP;
                end
                else if (!stat.start_in_grid)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_last = 1'b1;
                    cmd.res_src  = SRC_CODE;
                    cmd.res_code = ST_NO_PATH;
                end
                else
                begin
                    cmd.init_search = 1'b1;
                    state_next      = S_STEP;
                end
            end
            S_STEP:
            begin
                if (stat.dir_end)
                begin
                    // back out of the top cell
                    cmd.pop = 1'b1;
                    if (stat.level_one)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_last = 1'b1;
                        cmd.res_src  = SRC_CODE;
                        cmd.res_code = ST_NO_PATH;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_LOAD;
                    end
                end
                else
                begin
                    cmd.advance = 1'b1;
                    if (stat.nbr_is_goal)
                    begin
                        if (!stat.level_full)
                        begin
                            cmd.push       = 1'b1;
                            cmd.emit_clear = 1'b1;
                            state_next     = S_EMIT_RD;
                        end
                    end
                    else if (!stat.level_full && stat.nbr_free && !stat.budget_zero)
                    begin
                        cmd.flood_init = 1'b1;
                        state_next     = S_FLOOD;
                    end
                end
            end
            S_FLOOD:
            begin
                if (stat.flood_goal)
                begin
                    cmd.push      = 1'b1;
                    cmd.push_cand = 1'b1;
                    state_next    = S_STEP;
                end
                else if (stat.flood_stuck)
                begin
                    state_next = S_STEP;
                end
                else
                begin
                    cmd.flood_step = 1'b1;
                end
            end
            S_LOAD:
            begin
                cmd.load_top = 1'b1;
                state_next   = S_STEP;
            end
            S_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                cmd.res_load = 1'b1;
                cmd.res_src  = SRC_STACK;
                cmd.res_code = ST_STEP;
                cmd.emit_adv = 1'b1;
                state_next   = stat.emit_next_top ? S_EMIT_TOP : S_EMIT_RD;
            end
            S_EMIT_TOP:
            begin
                cmd.res_load = 1'b1;
                cmd.res_last = 1'b1;
                cmd.res_src  = SRC_TOP;
                cmd.res_code = ST_STEP;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ design/gmdfs_datapath.sv @@
// ----------------------------------------------------------------------------
// gmdfs_datapath
// wall map, visited marks, path stack memory, top-of-stack registers,
// bit-parallel reachability flood and result registers
// ----------------------------------------------------------------------------
module gmdfs_datapath
#(
    parameter int GRID_SIDE  = 8,
    parameter int PATH_DEPTH = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gmdfs_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [gmdfs_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [gmdfs_pkg::ROW_IDX_W-1:0]     row_index,
    input  logic [gmdfs_pkg::WALL_W-1:0]        wall_bits,
    input  gmdfs_pkg::ctrl_cmd_t                cmd,
    output gmdfs_pkg::dp_status_t               stat,
    output logic                                result_valid,
    output logic [gmdfs_pkg::STATUS_W-1:0]      status,
    output logic [gmdfs_pkg::COORD_W-1:0]       path_row,
    output logic [gmdfs_pkg::COORD_W-1:0]       path_col,
    output logic                                last
);
    import gmdfs_pkg::*;

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int CW    = $clog2(CELLS);
    localparam int GW    = $clog2(GRID_SIDE);
    localparam int KW    = (GW + 1 > CFG_W) ? GW + 1 : CFG_W;
    localparam int AW    = $clog2(PATH_DEPTH);
    localparam int LW    = $clog2(PATH_DEPTH + 1);
    localparam int EW    = 2 * KW + DIR_W;
    localparam logic [LW:0]   DEPTH_X  = (LW + 1)'(PATH_DEPTH);
    localparam logic [LW-1:0] DEPTH_L  = LW'(PATH_DEPTH);

    function automatic logic [CW-1:0] cell_of(input logic [KW-1:0] r, input logic [KW-1:0] c);
        return CW'(int'(r) * GRID_SIDE + int'(c));
    endfunction

    // configuration
    logic [CFG_W-1:0] start_row_reg;
    logic [CFG_W-1:0] start_col_reg;
    logic [CFG_W-1:0] goal_row_reg;
    logic [CFG_W-1:0] goal_col_reg;

    // search state
    logic [CELLS-1:0] wall_reg;
    logic [CELLS-1:0] visited_reg;
    logic [CELLS-1:0] visited_next;
    logic [CELLS-1:0] reach_reg;
    logic [CELLS-1:0] reach_grown;
    logic [CELLS-1:0] goal_adj;
    logic [CELLS-1:0] free_cells;
    logic [GRID_SIDE-1:0] row_bits;
    logic [KW-1:0]    top_row_reg;
    logic [KW-1:0]    top_col_reg;
    logic [DIR_W-1:0] top_dir_reg;
    logic [KW-1:0]    cand_row_reg;
    logic [KW-1:0]    cand_col_reg;
    logic [LW-1:0]    level_reg;
    logic [LW-1:0]    hop_reg;
    logic [LW-1:0]    emit_reg;

    // path stack memory
    logic [EW-1:0]    stack_mem [PATH_DEPTH];
    logic [EW-1:0]    rd_reg;
    logic [KW-1:0]    rd_row;
    logic [KW-1:0]    rd_col;
    logic [LW-1:0]    level_m1;
    logic [LW-1:0]    level_m2;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic             rd_en;

    // result registers
    logic                result_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [COORD_W-1:0]  path_row_reg;
    logic [COORD_W-1:0]  path_col_reg;
    logic                last_reg;

    // derived coordinates
    logic [KW-1:0] start_r;
    logic [KW-1:0] start_c;
    logic [KW-1:0] goal_r;
    logic [KW-1:0] goal_c;
    logic [KW-1:0] nbr_row;
    logic [KW-1:0] nbr_col;
    logic          nbr_ok;
    logic          nbr_in_grid;
    logic          goal_in_grid;
    logic [CW-1:0] nbr_idx;
    logic [CW-1:0] cand_idx;
    logic [CW-1:0] top_idx;
    logic [CW-1:0] start_idx;
    logic [CW-1:0] goal_idx;

    assign start_r = KW'(start_row_reg);
    assign start_c = KW'(start_col_reg);
    assign goal_r  = KW'(goal_row_reg);
    assign goal_c  = KW'(goal_col_reg);

    assign start_idx = cell_of(start_r, start_c);
    assign goal_idx  = cell_of(goal_r, goal_c);
    assign top_idx   = cell_of(top_row_reg, top_col_reg);
    assign cand_idx  = cell_of(cand_row_reg, cand_col_reg);
    assign nbr_idx   = cell_of(nbr_row, nbr_col);

    assign free_cells = ~wall_reg & ~visited_reg;

    assign rd_row = rd_reg[EW-1 -: KW];
    assign rd_col = rd_reg[DIR_W+KW-1 -: KW];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_row_reg <= START_ROW_RESET;
            start_col_reg <= START_COL_RESET;
            goal_row_reg  <= GOAL_ROW_RESET;
            goal_col_reg  <= GOAL_COL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_START_ROW: start_row_reg <= cfg_wdata;
                REG_START_COL: start_col_reg <= cfg_wdata;
                REG_GOAL_ROW:  goal_row_reg  <= cfg_wdata;
                REG_GOAL_COL:  goal_col_reg  <= cfg_wdata;
                default:       start_row_reg <= start_row_reg;
            endcase
        end
    end

    // wall row write, columns beyond the grid dropped
    always_comb
    begin
        for (int j = 0; j < GRID_SIDE; j++)
        begin
            row_bits[j] = (j < WALL_W) ? wall_bits[j % WALL_W] : 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_row)
        begin
            for (int i = 0; i < CELLS; i++)
            begin
                if (int'(row_index) == i / GRID_SIDE)
                begin
                    wall_reg[i] <= row_bits[i % GRID_SIDE];
                end
            end
        end
    end

    // neighbor of the top cell in the current direction
    always_comb
    begin
        nbr_row = top_row_reg;
        nbr_col = top_col_reg;
        nbr_ok  = 1'b1;
        case (top_dir_reg)
            DIR_EAST:  nbr_col = top_col_reg + KW'(1);
            DIR_SOUTH: nbr_row = top_row_reg + KW'(1);
            DIR_WEST:
            begin
                nbr_col = top_col_reg - KW'(1);
                nbr_ok  = (top_col_reg != '0);
            end
            DIR_NORTH:
            begin
                nbr_row = top_row_reg - KW'(1);
                nbr_ok  = (top_row_reg != '0);
            end
            default:   nbr_ok = 1'b0;
        endcase
    end

    assign nbr_in_grid  = nbr_ok && (int'(nbr_row) < GRID_SIDE) && (int'(nbr_col) < GRID_SIDE);
    assign goal_in_grid = (int'(goal_r) < GRID_SIDE) && (int'(goal_c) < GRID_SIDE);

    // cells from which one step lands on the goal
    always_comb
    begin
        for (int i = 0; i < CELLS; i++)
        begin
            goal_adj[i] = ((int'(goal_r) == i / GRID_SIDE)
                              && (int'(goal_c) == i % GRID_SIDE + 1))
                       || ((int'(goal_r) == i / GRID_SIDE + 1)
                              && (int'(goal_c) == i % GRID_SIDE))
                       || ((i % GRID_SIDE > 0) && (int'(goal_r) == i / GRID_SIDE)
                              && (int'(goal_c) == i % GRID_SIDE - 1))
                       || ((i / GRID_SIDE > 0) && (int'(goal_r) == i / GRID_SIDE - 1)
                              && (int'(goal_c) == i % GRID_SIDE));
        end
    end

    // one flood wave over free cells
    always_comb
    begin
        for (int i = 0; i < CELLS; i++)
        begin
            reach_grown[i] = reach_reg[i]
                | (free_cells[i]
                   & (((i % GRID_SIDE < GRID_SIDE - 1) && reach_reg[(i + 1) % CELLS])
                    | ((i % GRID_SIDE > 0) && reach_reg[(i + CELLS - 1) % CELLS])
                    | ((i / GRID_SIDE < GRID_SIDE - 1) && reach_reg[(i + GRID_SIDE) % CELLS])
                    | ((i / GRID_SIDE > 0) && reach_reg[(i + CELLS - GRID_SIDE) % CELLS])));
        end
    end

    // status to the controller
    always_comb
    begin
        stat.start_in_grid = (int'(start_r) < GRID_SIDE) && (int'(start_c) < GRID_SIDE);
        stat.start_wall    = stat.start_in_grid && wall_reg[start_idx];
        stat.goal_wall     = goal_in_grid && wall_reg[goal_idx];
        stat.start_is_goal = (start_r == goal_r) && (start_c == goal_c);
        stat.dir_end       = (top_dir_reg == DIR_DONE);
        stat.level_one     = (level_reg == LW'(1));
        stat.level_full    = (level_reg == DEPTH_L);
        stat.budget_zero   = ({1'b0, level_reg} + (LW + 1)'(1)) == DEPTH_X;
        stat.nbr_is_goal   = nbr_ok && (nbr_row == goal_r) && (nbr_col == goal_c);
        stat.nbr_free      = nbr_in_grid ? free_cells[nbr_idx] : 1'b0;
        stat.flood_goal    = |(reach_reg & goal_adj);
        stat.flood_stuck   = (reach_grown == reach_reg)
                          || (({1'b0, hop_reg} + {1'b0, level_reg} + (LW + 1)'(1)) == DEPTH_X);
        stat.emit_next_top = ({1'b0, emit_reg} + (LW + 1)'(2)) == {1'b0, level_reg};
    end

    // visited marks
    always_comb
    begin
        visited_next = visited_reg;
        if (cmd.init_search)
        begin
            for (int i = 0; i < CELLS; i++)
            begin
                visited_next[i] = (CW'(i) == start_idx);
            end
        end
        else if (cmd.push && cmd.push_cand)
        begin
            visited_next[cand_idx] = 1'b1;
        end
        else if (cmd.pop)
        begin
            visited_next[top_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= '0;
        end
        else
        begin
            visited_reg <= visited_next;
        end
    end

    // stack control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else if (cmd.init_search)
        begin
            level_reg <= LW'(1);
        end
        else if (cmd.push)
        begin
            level_reg <= level_reg + LW'(1);
        end
        else if (cmd.pop)
        begin
            level_reg <= level_m1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_search)
        begin
            top_row_reg <= start_r;
            top_col_reg <= start_c;
            top_dir_reg <= DIR_EAST;
        end
        else if (cmd.push)
        begin
            top_row_reg <= cmd.push_cand ? cand_row_reg : nbr_row;
            top_col_reg <= cmd.push_cand ? cand_col_reg : nbr_col;
            top_dir_reg <= DIR_EAST;
        end
        else if (cmd.load_top)
        begin
            top_row_reg <= rd_row;
            top_col_reg <= rd_col;
            top_dir_reg <= rd_reg[DIR_W-1:0];
        end
        else if (cmd.advance)
        begin
            top_dir_reg <= top_dir_reg + DIR_W'(1);
        end

        if (cmd.advance)
        begin
            cand_row_reg <= nbr_row;
            cand_col_reg <= nbr_col;
        end

        if (cmd.flood_init)
        begin
            for (int i = 0; i < CELLS; i++)
            begin
                reach_reg[i] <= (CW'(i) == nbr_idx);
            end
            hop_reg <= LW'(1);
        end
        else if (cmd.flood_step)
        begin
            reach_reg <= reach_grown;
            hop_reg   <= hop_reg + LW'(1);
        end

        if (cmd.emit_clear)
        begin
            emit_reg <= '0;
        end
        else if (cmd.emit_adv)
        begin
            emit_reg <= emit_reg + LW'(1);
        end
    end

    // path stack memory: entries below the top cell
    assign level_m1 = level_reg - LW'(1);
    assign level_m2 = level_reg - LW'(2);
    assign wr_addr  = level_m1[AW-1:0];
    assign rd_addr  = cmd.emit_rd ? emit_reg[AW-1:0] : level_m2[AW-1:0];
    assign rd_en    = cmd.emit_rd || (cmd.pop && !stat.level_one);

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_mem[wr_addr] <= {top_row_reg, top_col_reg, top_dir_reg};
        end
        if (rd_en)
        begin
            rd_reg <= stack_mem[rd_addr];
        end
    end

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            status_reg <= cmd.res_code;
            last_reg   <= cmd.res_last;
            case (cmd.res_src)
                SRC_START:
                begin
                    path_row_reg <= start_row_reg;
                    path_col_reg <= start_col_reg;
                end
                SRC_STACK:
                begin
                    path_row_reg <= rd_row[COORD_W-1:0];
                    path_col_reg <= rd_col[COORD_W-1:0];
                end
                SRC_TOP:
                begin
                    path_row_reg <= top_row_reg[COORD_W-1:0];
                    path_col_reg <= top_col_reg[COORD_W-1:0];
                end
                default:
                begin
                    path_row_reg <= '0;
                    path_col_reg <= '0;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign path_row     = path_row_reg;
    assign path_col     = path_col_reg;
    assign last         = last_reg;

endmodule

@@ design/grid_maze_dfs_path_search.sv @@
// ----------------------------------------------------------------------------
// grid_maze_dfs_path_search
// Loads a square wall map one row per transfer on start/busy: a transfer is
// taken at a clock edge with start high and busy low, and writes row_index.
// A transfer with last_row set launches a backtracking depth-first search
// from the start cell to the goal cell (cfg_we/cfg_addr/cfg_wdata set them).
// Row transfers without last_row leave busy low. Results come out one per
// result_valid pulse: the path cells in order from start to goal, or one
// status item; last marks the final one. The receiver cannot stall. A
// blocked start or goal cell gives its status straight from the check
// state; otherwise the search tries one direction per step, runs the
// flood waves of a reachability check before each step forward and
// reloads the top cell from the path stack on each back step. A path
// then streams out one cell per path stack read, so the search time is
// data dependent and the path stack memory port sets the output pace.
// Reset clears the search state and returns start and goal to their
// defaults; the wall map holds garbage until rows are written.
// ----------------------------------------------------------------------------
module grid_maze_dfs_path_search
#(
    parameter int GRID_SIDE  = 8,
    parameter int PATH_DEPTH = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [gmdfs_pkg::ROW_IDX_W-1:0]     row_index,
    input  logic [gmdfs_pkg::WALL_W-1:0]        wall_bits,
    input  logic                                last_row,
    input  logic                                cfg_we,
    input  logic [gmdfs_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [gmdfs_pkg::CFG_W-1:0]         cfg_wdata,
    output logic                                result_valid,
    output logic [gmdfs_pkg::STATUS_W-1:0]      status,
    output logic [gmdfs_pkg::COORD_W-1:0]       path_row,
    output logic [gmdfs_pkg::COORD_W-1:0]       path_col,
    output logic                                last
);
    import gmdfs_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    gmdfs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .last_row (last_row),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    gmdfs_datapath
    #(
        .GRID_SIDE  (GRID_SIDE),
        .PATH_DEPTH (PATH_DEPTH)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .row_index    (row_index),
        .wall_bits    (wall_bits),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .status       (status),
        .path_row     (path_row),
        .path_col     (path_col),
        .last         (last)
    );

endmodule

@@ design/gmdfs_checker.sv @@
// ----------------------------------------------------------------------------
// gmdfs_checker
// port-level checks of the result stream, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gmdfs_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               last_row,
    input logic                               result_valid,
    input logic [gmdfs_pkg::STATUS_W-1:0]     status,
    input logic                               last
);
    import gmdfs_pkg::*;

    // a status item always carries last
    `ASSERT_SAME_CYCLE(a_status_is_last, clk, rst_n, result_valid && (status != ST_STEP), last)

    // results before the final one come while the search is still running
    `ASSERT_SAME_CYCLE(a_mid_result_busy, clk, rst_n, result_valid && !last, busy)

    // nothing follows the final result directly
    `ASSERT_NEXT_CYCLE(a_gap_after_last, clk, rst_n, result_valid && last, !result_valid)

    // a final row transfer starts a search
    `ASSERT_NEXT_CYCLE(a_search_starts, clk, rst_n, start && !busy && last_row, busy)

endmodule

bind grid_maze_dfs_path_search gmdfs_checker u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .last_row     (last_row),
    .result_valid (result_valid),
    .status       (status),
    .last         (last)
);

@@ tb/tb_grid_maze_dfs_path_search.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_maze_dfs_path_search
// Loads wall maps row by row and checks every path cell or status item that
// the search returns against an in-bench depth-first search with the same
// neighbor order, backtracking and reachability pruning. A directed part
// covers open, blocked, unreachable, single-cell and long winding paths.
// Random mazes of varied density follow under several start and goal
// settings, with sender gaps and partial or noisy row loads.
// ----------------------------------------------------------------------------
module tb_grid_maze_dfs_path_search;

    import gmdfs_pkg::*;

    localparam int GRID_SIDE     = 8;
    localparam int PATH_DEPTH    = 64;
    localparam int CELL_COUNT    = GRID_SIDE * GRID_SIDE;
    localparam int QUIET_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = 8;
    localparam int ROW_TARGET    = 410;
    localparam int PHASE_ROWS    = 55;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  col;
        logic                last;
    } path_cell_t;

    class maze_path_board;
        logic [WALL_W-1:0] wall_rows [GRID_SIDE];
        bit                on_path [CELL_COUNT];
        int                trail_r [PATH_DEPTH];
        int                trail_c [PATH_DEPTH];
        int                trail_dir [PATH_DEPTH];
        int                trail_len;
        logic [CFG_W-1:0]  regs [4];
        path_cell_t        cells_due [$];
        int                fails;
        int                searches;
        int                paths;
        int                no_paths;
        int                start_blocks;
        int                goal_blocks;
        int                longest;
        int                cells_checked;

        function new();
            regs[REG_START_ROW] = START_ROW_RESET;
            regs[REG_START_COL] = START_COL_RESET;
            regs[REG_GOAL_ROW]  = GOAL_ROW_RESET;
            regs[REG_GOAL_COL]  = GOAL_COL_RESET;
            foreach (wall_rows[i]) wall_rows[i] = '0;
            trail_len     = 0;
            fails         = 0;
            searches      = 0;
            paths         = 0;
            no_paths      = 0;
            start_blocks  = 0;
            goal_blocks   = 0;
            longest       = 0;
            cells_checked = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            regs[idx] = val;
        endfunction

        function int pending();
            return cells_due.size();
        endfunction

        function int row_step(int d);
            case (d)
                DIR_SOUTH: return 1;
                DIR_NORTH: return -1;
                default:   return 0;
            endcase
        endfunction

        function int col_step(int d);
            case (d)
                DIR_EAST: return 1;
                DIR_WEST: return -1;
                default:  return 0;
            endcase
        endfunction

        function bit in_grid(int r, int c);
            return r >= 0 && r < GRID_SIDE && c >= 0 && c < GRID_SIDE;
        endfunction

        function bit is_wall(int r, int c);
            return in_grid(r, c) && wall_rows[r][c];
        endfunction

        function bit is_open(int r, int c);
            return in_grid(r, c) && !wall_rows[r][c] && !on_path[r * GRID_SIDE + c];
        endfunction

        // steps to the goal over open cells, -1 when it cannot be reached
        function int goal_hops(int r0, int c0);
            int frontier [CELL_COUNT];
            int hops [CELL_COUNT];
            int head, tail, here, cr, cc, nr, nc, gr, gc, d, idx;
            gr = int'(regs[REG_GOAL_ROW]);
            gc = int'(regs[REG_GOAL_COL]);
            foreach (hops[i]) hops[i] = -1;
            head = 0;
            tail = 1;
            frontier[0] = r0 * GRID_SIDE + c0;
            hops[frontier[0]] = 0;
            while (head < tail)
            begin
                here = frontier[head];
                head++;
                cr = here / GRID_SIDE;
                cc = here % GRID_SIDE;
                for (d = DIR_EAST; d <= DIR_NORTH; d++)
                begin
                    nr = cr + row_step(d);
                    nc = cc + col_step(d);
                    if (nr == gr && nc == gc)
                        return hops[here] + 1;
                    if (is_open(nr, nc))
                    begin
                        idx = nr * GRID_SIDE + nc;
                        if (hops[idx] < 0)
                        begin
                            hops[idx] = hops[here] + 1;
                            frontier[tail] = idx;
                            tail++;
                        end
                    end
                end
            end
            return -1;
        endfunction

        function void push_trail(int r, int c);
            trail_r[trail_len]   = r;
            trail_c[trail_len]   = c;
            trail_dir[trail_len] = DIR_EAST;
            trail_len++;
        endfunction

        // backtracking search, leaves the path found in the trail arrays
        function bit find_path();
            int sr, sc, gr, gc, top, r, c, nr, nc, d, hops;
            sr = int'(regs[REG_START_ROW]);
            sc = int'(regs[REG_START_COL]);
            gr = int'(regs[REG_GOAL_ROW]);
            gc = int'(regs[REG_GOAL_COL]);
            foreach (on_path[i]) on_path[i] = 1'b0;
            trail_len = 0;
            if (sr == gr && sc == gc)
            begin
                push_trail(sr, sc);
                return 1'b1;
            end
            if (!is_open(sr, sc))
                return 1'b0;
            push_trail(sr, sc);
            on_path[sr * GRID_SIDE + sc] = 1'b1;
            while (trail_len > 0)
            begin
                top = trail_len - 1;
                r   = trail_r[top];
                c   = trail_c[top];
                d   = trail_dir[top];
                if (d >= DIR_DONE)
                begin
                    on_path[r * GRID_SIDE + c] = 1'b0;
                    trail_len--;
                    continue;
                end
                trail_dir[top] = d + 1;
                nr = r + row_step(d);
                nc = c + col_step(d);
                if (nr == gr && nc == gc)
                begin
                    if (trail_len < PATH_DEPTH)
                    begin
                        push_trail(nr, nc);
                        return 1'b1;
                    end
                    continue;
                end
                if (trail_len < PATH_DEPTH && is_open(nr, nc))
                begin
                    hops = goal_hops(nr, nc);
                    if (hops >= 0 && trail_len + 1 + hops <= PATH_DEPTH)
                    begin
                        push_trail(nr, nc);
                        on_path[nr * GRID_SIDE + nc] = 1'b1;
                    end
                end
            end
            return 1'b0;
        endfunction

        function void add_status(logic [STATUS_W-1:0] code);
            cells_due.push_back(path_cell_t'{status: code, row: '0, col: '0, last: 1'b1});
        endfunction

        // accepted row transfer
        function void take_row(logic [ROW_IDX_W-1:0] row, logic [WALL_W-1:0] bits, logic lr);
            int k;
            wall_rows[row] = bits;
            if (!lr)
                return;
            searches++;
            if (is_wall(int'(regs[REG_START_ROW]), int'(regs[REG_START_COL])))
            begin
                add_status(ST_START_BLOCKED);
                start_blocks++;
            end
            else if (is_wall(int'(regs[REG_GOAL_ROW]), int'(regs[REG_GOAL_COL])))
            begin
                add_status(ST_GOAL_BLOCKED);
                goal_blocks++;
            end
            else if (!find_path())
            begin
                add_status(ST_NO_PATH);
                no_paths++;
            end
            else
            begin
                paths++;
                if (trail_len > longest)
                    longest = trail_len;
                for (k = 0; k < trail_len; k++)
                    cells_due.push_back(path_cell_t'{
                        status: ST_STEP,
                        row:    COORD_W'(trail_r[k]),
                        col:    COORD_W'(trail_c[k]),
                        last:   (k == trail_len - 1)});
            end
        endfunction

        // result transfer, compared against the oldest expected cell
        function void check_cell(path_cell_t got);
            path_cell_t want;
            if (cells_due.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("unexpected result: status %0d row %0d col %0d last %0d",
                             got.status, got.row, got.col, got.last);
                return;
            end
            want = cells_due.pop_front();
            cells_checked++;
            if (got.status != want.status || got.row != want.row ||
                got.col != want.col || got.last != want.last)
            begin
                fails++;
                if (fails <= 10)
                begin
                    $display("result %0d: expected status %0d row %0d col %0d last %0d",
                             cells_checked, want.status, want.row, want.col, want.last);
                    $display("    got status %0d row %0d col %0d last %0d",
                             got.status, got.row, got.col, got.last);
                end
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [ROW_IDX_W-1:0]  row_index;
    logic [WALL_W-1:0]     wall_bits;
    logic                  last_row;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  result_valid;
    logic [STATUS_W-1:0]   status;
    logic [COORD_W-1:0]    path_row;
    logic [COORD_W-1:0]    path_col;
    logic                  last;

    maze_path_board board;
    int             idle_pct;
    int             rows_sent;
    int             quiet_cycles;

    grid_maze_dfs_path_search
    #(
        .GRID_SIDE  (GRID_SIDE),
        .PATH_DEPTH (PATH_DEPTH)
    )
    i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .row_index    (row_index),
        .wall_bits    (wall_bits),
        .last_row     (last_row),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .status       (status),
        .path_row     (path_row),
        .path_col     (path_col),
        .last         (last)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            board.check_cell(path_cell_t'{status: status, row: path_row, col: path_col,
                                          last: last});
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_row(input int r, input int bits, input bit lr);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        start     <= 1'b1;
        row_index <= ROW_IDX_W'(r);
        wall_bits <= WALL_W'(bits);
        last_row  <= lr;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.take_row(ROW_IDX_W'(r), WALL_W'(bits), lr);
        rows_sent++;
    endtask

    // wait until every expected result is in and the block is idle
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0 || busy) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_W'(val);
        @(posedge clk);
        board.set_reg(idx, CFG_W'(val));
    endtask

    task automatic set_cfg(input int sr, input int sc, input int gr, input int gc);
        write_reg(REG_START_ROW, sr);
        write_reg(REG_START_COL, sc);
        write_reg(REG_GOAL_ROW, gr);
        write_reg(REG_GOAL_COL, gc);
        cfg_we <= 1'b0;
    endtask

    task automatic load_maze(input int wall_pct, input bit full_load);
        logic [WALL_W-1:0] rows [GRID_SIDE];
        int                order [GRID_SIDE];
        int                count, k, j, tmp;
        for (k = 0; k < GRID_SIDE; k++)
        begin
            order[k] = k;
            for (j = 0; j < GRID_SIDE; j++)
                rows[k][j] = ($urandom_range(0, 99) < wall_pct);
        end
        // mostly keep start and goal open so the search gets going
        if ($urandom_range(0, 99) < 85)
        begin
            rows[board.regs[REG_START_ROW]][board.regs[REG_START_COL]] = 1'b0;
            rows[board.regs[REG_GOAL_ROW]][board.regs[REG_GOAL_COL]]   = 1'b0;
        end
        for (k = GRID_SIDE - 1; k > 0; k--)
        begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        count = full_load ? GRID_SIDE : $urandom_range(1, GRID_SIDE);
        for (k = 0; k < count; k++)
            send_row(order[k], rows[order[k]], k == count - 1);
    endtask

    initial
    begin
        int p, k, pick, phase_base;
        board        = new();
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        row_index    = '0;
        wall_bits    = '0;
        last_row     = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = REG_START_ROW;
        cfg_wdata    = '0;
        idle_pct     = 0;
        rows_sent    = 0;
        quiet_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // open grid, every row loaded before the first search
        for (k = 0; k < GRID_SIDE; k++)
            send_row(k, 8'h00, k == GRID_SIDE - 1);
        // start and goal both walls
        send_row(7, 8'h80, 1'b0);
        send_row(0, 8'h02, 1'b1);
        // goal wall only
        send_row(0, 8'h00, 1'b1);
        // goal walled in
        send_row(7, 8'h40, 1'b0);
        send_row(6, 8'h80, 1'b1);
        // winding corridor
        send_row(0, 8'h00, 1'b0);
        send_row(1, 8'h7f, 1'b0);
        send_row(2, 8'h00, 1'b0);
        send_row(3, 8'hfe, 1'b0);
        send_row(4, 8'h00, 1'b0);
        send_row(5, 8'h7f, 1'b0);
        send_row(6, 8'h00, 1'b0);
        send_row(7, 8'h00, 1'b1);
        // start equals goal, open then on a wall
        settle();
        set_cfg(3, 3, 3, 3);
        send_row(3, 8'ha5, 1'b1);
        send_row(3, 8'h08, 1'b1);

        for (p = 1; p <= 7; p++)
        begin
            settle();
            case (p)
                1:
                begin
                    set_cfg(0, 0, 7, 7);
                    idle_pct = 0;
                end
                2:
                begin
                    set_cfg(7, 7, 0, 0);
                    idle_pct = 46;
                end
                3:
                begin
                    set_cfg(0, 7, 7, 0);
                    idle_pct = 11;
                end
                4:
                begin
                    // results cannot be stalled, and this phase sends rows with no sender gaps
                    set_cfg(7, 0, 0, 7);
                    idle_pct = 0;
                end
                default:
                begin
                    set_cfg($urandom_range(0, 7), $urandom_range(0, 7),
                            $urandom_range(0, 7), $urandom_range(0, 7));
                    idle_pct = (p == 5) ? 46 : (p == 6) ? 0 : 11;
                end
            endcase
            phase_base = rows_sent;
            while (rows_sent - phase_base < PHASE_ROWS || (p == 7 && rows_sent < ROW_TARGET))
            begin
                if ($urandom_range(0, 99) < 8)
                    settle();
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    load_maze($urandom_range(0, 45), $urandom_range(0, 99) < 60);
                else if (pick < 88)
                    send_row($urandom_range(0, 7), $urandom_range(0, 255), 1'b1);
                else
                    repeat ($urandom_range(1, 3))
                        send_row($urandom_range(0, 7), $urandom_range(0, 255), 1'b0);
            end
        end

        settle();
        if (board.pending() != 0)
        begin
            $display("%0d expected results never arrived", board.pending());
            board.fails += board.pending();
        end
        $display("%0d row transfers, %0d searches: %0d paths (longest %0d cells), %0d no path",
                 rows_sent, board.searches, board.paths, board.longest, board.no_paths);
        $display("%0d start blocked, %0d goal blocked, %0d result transfers checked",
                 board.start_blocks, board.goal_blocks, board.cells_checked);
        if (board.fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/gmdfs_pkg.sv
design/gmdfs_ctrl.sv
design/gmdfs_datapath.sv
design/grid_maze_dfs_path_search.sv
design/gmdfs_checker.sv
tb/tb_grid_maze_dfs_path_search.sv
